[sv/text_console_writer_top_defines.svh]
// Assertion helpers shared by the console writer RTL
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked after the antecedent, not in the same cycle
`define TCW_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[sv/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  localparam int unsigned ADDR_W       = 14;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned ATTR_W       = 8;
  localparam int unsigned CELLS_W      = 15;
  localparam int unsigned CFG_DATA_W   = 15;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned END_W        = 15;
  localparam int unsigned SUM_W        = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned OUT_DATA_W   = 64;

  localparam int unsigned SCREEN_COLS  = 80;
  localparam int unsigned SCREEN_CELLS = 2000;
  localparam int unsigned TAB_CELLS    = 4;
  localparam int unsigned VMEM_CELLS   = 1 << ADDR_W;
  localparam int unsigned CNT_W        = $clog2(TAB_CELLS + 1);

  // row remainder by reciprocal multiply; exact while 2^ADDR_W <= 2^RECIP_SHIFT / SCREEN_COLS
  localparam int unsigned RECIP_SHIFT  = 22;
  localparam int unsigned ROW_RECIP    = ((1 << RECIP_SHIFT) + SCREEN_COLS - 1) / SCREEN_COLS;
  localparam int unsigned RECIP_W      = $clog2(ROW_RECIP + 1);
  localparam int unsigned PROD_W       = ADDR_W + RECIP_W;
  localparam int unsigned QUOT_W       = ADDR_W - $clog2(SCREEN_COLS) + 1;
  localparam int unsigned REM_W        = $clog2(SCREEN_COLS);

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TAB_FILL  = 8'd0;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT       = 2'd0,
    OP_SCROLL_UP   = 2'd1,
    OP_SCROLL_DOWN = 2'd2,
    OP_NOP         = 2'd3
  } opcode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REGION_BASE  = 2'd0,
    CFG_REGION_CELLS = 2'd1,
    CFG_DEFAULT_ATTR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [CELLS_W-1:0] cells;
    logic [ATTR_W-1:0]  attr;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
  } row_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } row_rsp_t;

endpackage

`default_nettype wire

[sv/tcw_cell_mem.sv]
`default_nettype none

module tcw_cell_mem (
  input  wire logic                      clk_i,
  input  wire tcw_pkg::mem_req_t         req_i,
  output logic [tcw_pkg::CHAR_W-1:0]     rdata_o
);

  logic [tcw_pkg::CHAR_W-1:0] mem_q [tcw_pkg::VMEM_CELLS];
  logic [tcw_pkg::CHAR_W-1:0] rdata_q;

  // single port, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/tcw_row_calc.sv]
`default_nettype none

// Offset within a screen row: two stages, reciprocal multiply then back-multiply.
module tcw_row_calc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_pkg::row_req_t req_i,
  output tcw_pkg::row_rsp_t      rsp_o
);

  logic                         v1_q, v2_q;
  logic [tcw_pkg::ADDR_W-1:0]   d1_q;
  logic [tcw_pkg::PROD_W-1:0]   prod_q;
  logic [tcw_pkg::REM_W-1:0]    rem_q;
  logic [tcw_pkg::QUOT_W-1:0]   quot;
  logic [tcw_pkg::ADDR_W-1:0]   back;
  logic [tcw_pkg::ADDR_W-1:0]   diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      d1_q   <= req_i.dividend;
      prod_q <= tcw_pkg::PROD_W'(req_i.dividend) * tcw_pkg::PROD_W'(tcw_pkg::ROW_RECIP);
    end
    if (v1_q) begin
      rem_q <= diff[tcw_pkg::REM_W-1:0];
    end
  end

  always_comb begin
    quot = prod_q[tcw_pkg::RECIP_SHIFT +: tcw_pkg::QUOT_W];
    back = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(quot) * tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS));
    diff = d1_q - back;
  end

  assign rsp_o.done = v2_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[sv/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcw_pkg::cfg_t                 cfg_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    s_axis_tdata,   // char_code
  input  wire logic [tcw_pkg::OP_W-1:0]      s_axis_tuser,   // opcode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // cell_address, cell_char, cell_attr, cursor_pos, view_start, zero pad
  output logic [tcw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [0:0]                         m_axis_tuser,   // write_valid
  output logic                               m_axis_tlast,
  output tcw_pkg::mem_req_t                  mem_req_o,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    mem_rdata_i,
  output tcw_pkg::row_req_t                  row_req_o,
  input  wire tcw_pkg::row_rsp_t             row_rsp_i
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_NL_WAIT = 3'd3;
  localparam logic [2:0] ST_BS_READ = 3'd4;
  localparam logic [2:0] ST_SCROLL  = 3'd5;
  localparam logic [2:0] ST_EMIT    = 3'd6;

  localparam int unsigned AW = tcw_pkg::ADDR_W;
  localparam int unsigned SW = tcw_pkg::SUM_W;
  localparam int unsigned CW = tcw_pkg::CNT_W;
  localparam int unsigned PAD_W = tcw_pkg::OUT_DATA_W - 3 * AW - tcw_pkg::CHAR_W
                                  - tcw_pkg::ATTR_W;

  logic [2:0]                 state_q, state_d;
  logic [AW-1:0]              clr_q, clr_d;
  tcw_pkg::opcode_e           op_q, op_d;
  logic [tcw_pkg::CHAR_W-1:0] ch_q, ch_d;
  logic [AW-1:0]              cursor_q, cursor_d;
  logic [AW-1:0]              view_q, view_d;
  logic [CW-1:0]              nwr_q, nwr_d;
  logic [CW-1:0]              wcnt_q, wcnt_d;
  logic [AW-1:0]              wa_q, wa_d;
  logic [tcw_pkg::CHAR_W-1:0] wch_q, wch_d;

  logic                       ovalid_q;
  logic                       olast_q, owv_q;
  logic [AW-1:0]              oaddr_q, ocur_q, oview_q;
  logic [tcw_pkg::CHAR_W-1:0] ochar_q;
  logic [tcw_pkg::ATTR_W-1:0] oattr_q;

  logic                       load_out;
  logic                       nlast, nwv;
  logic [AW-1:0]              naddr;
  logic [tcw_pkg::CHAR_W-1:0] nchar;
  logic [tcw_pkg::ATTR_W-1:0] nattr;

  logic [SW-1:0]              end_sum, end_ext, cur_ext, view_ext, base_ext;
  logic                       nl_ok, pr_ok, tab_ok, bs_ok, dn_ok, up_ok, up_full;
  logic                       scroll_need, out_free, emit_last;

  always_comb begin
    end_sum  = SW'(cfg_i.base) + SW'(cfg_i.cells);
    end_ext  = (end_sum > SW'(tcw_pkg::VMEM_CELLS)) ? SW'(tcw_pkg::VMEM_CELLS) : end_sum;
    cur_ext  = SW'(cursor_q);
    view_ext = SW'(view_q);
    base_ext = SW'(cfg_i.base);

    nl_ok       = (cur_ext + SW'(tcw_pkg::SCREEN_COLS)) < end_ext;
    pr_ok       = (cur_ext + SW'(1)) < end_ext;
    tab_ok      = (cur_ext + SW'(tcw_pkg::TAB_CELLS)) < end_ext;
    bs_ok       = cursor_q > cfg_i.base;
    dn_ok       = (view_ext + SW'(tcw_pkg::SCREEN_CELLS)) < end_ext;
    up_ok       = view_q > cfg_i.base;
    up_full     = view_ext >= (base_ext + SW'(tcw_pkg::SCREEN_COLS));
    scroll_need = cur_ext >= (view_ext + SW'(tcw_pkg::SCREEN_CELLS));
    out_free    = !ovalid_q || m_axis_tready;
    emit_last   = (wcnt_q == (nwr_q - CW'(1)));
  end

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    op_d     = op_q;
    ch_d     = ch_q;
    cursor_d = cursor_q;
    view_d   = view_q;
    nwr_d    = nwr_q;
    wcnt_d   = wcnt_q;
    wa_d     = wa_q;
    wch_d    = wch_q;

    mem_req_o          = '0;
    row_req_o.start    = 1'b0;
    row_req_o.dividend = cursor_q - cfg_i.base;

    load_out = 1'b0;
    nwv      = 1'b0;
    nlast    = 1'b1;
    naddr    = '0;
    nchar    = '0;
    nattr    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = tcw_pkg::CH_SPACE;
        clr_d           = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = tcw_pkg::opcode_e'(s_axis_tuser);
          ch_d    = s_axis_tdata;
          nwr_d   = '0;
          wcnt_d  = '0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_EMIT;
        case (op_q)
          tcw_pkg::OP_SCROLL_UP: begin
            if (up_ok) begin
              view_d = up_full ? view_q - AW'(tcw_pkg::SCREEN_COLS) : cfg_i.base;
            end
          end
          tcw_pkg::OP_SCROLL_DOWN: begin
            if (dn_ok) begin
              view_d = view_q + AW'(tcw_pkg::SCREEN_COLS);
            end
          end
          tcw_pkg::OP_PRINT: begin
            state_d = ST_SCROLL;
            case (ch_q)
              tcw_pkg::CH_NEWLINE: begin
                if (nl_ok) begin
                  if (cursor_q < cfg_i.base) begin
                    cursor_d = cfg_i.base;
                  end else begin
                    row_req_o.start = 1'b1;
                    state_d         = ST_NL_WAIT;
                  end
                end
              end
              tcw_pkg::CH_BACKSPACE: begin
                if (bs_ok) begin
                  mem_req_o.en   = 1'b1;
                  mem_req_o.addr = cursor_q - AW'(1);
                  state_d        = ST_BS_READ;
                end
              end
              tcw_pkg::CH_TAB: begin
                if (tab_ok) begin
                  nwr_d    = CW'(tcw_pkg::TAB_CELLS);
                  wa_d     = cursor_q;
                  wch_d    = tcw_pkg::CH_TAB_FILL;
                  cursor_d = cursor_q + AW'(tcw_pkg::TAB_CELLS);
                end
              end
              default: begin
                if (pr_ok) begin
                  nwr_d    = CW'(1);
                  wa_d     = cursor_q;
                  wch_d    = ch_q;
                  cursor_d = cursor_q + AW'(1);
                end
              end
            endcase
          end
          default: ;
        endcase
      end
      ST_NL_WAIT: begin
        if (row_rsp_i.done) begin
          // start of next row: drop the offset within the row, add one row
          cursor_d = cursor_q - AW'(row_rsp_i.rem) + AW'(tcw_pkg::SCREEN_COLS);
          state_d  = ST_SCROLL;
        end
      end
      ST_BS_READ: begin
        state_d = ST_SCROLL;
        if (mem_rdata_i == tcw_pkg::CH_TAB_FILL) begin
          // step back over a tab fill, not below the region start
          cursor_d = (cur_ext < (base_ext + SW'(tcw_pkg::TAB_CELLS))) ?
                     cfg_i.base : cursor_q - AW'(tcw_pkg::TAB_CELLS);
        end else begin
          cursor_d = cursor_q - AW'(1);
          nwr_d    = CW'(1);
          wa_d     = cursor_q - AW'(1);
          wch_d    = tcw_pkg::CH_SPACE;
        end
      end
      ST_SCROLL: begin
        if (scroll_need && dn_ok) begin
          view_d = view_q + AW'(tcw_pkg::SCREEN_COLS);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (nwr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            mem_req_o.en    = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = wa_q + AW'(wcnt_q);
            mem_req_o.wdata = wch_q;
            nwv             = 1'b1;
            nlast           = emit_last;
            naddr           = wa_q + AW'(wcnt_q);
            nchar           = wch_q;
            nattr           = cfg_i.attr;
            wcnt_d          = wcnt_q + CW'(1);
            if (emit_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cursor_q <= '0;
      view_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cursor_q <= cursor_d;
      view_q   <= view_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ch_q   <= ch_d;
    nwr_q  <= nwr_d;
    wcnt_q <= wcnt_d;
    wa_q   <= wa_d;
    wch_q  <= wch_d;
    if (load_out) begin
      owv_q   <= nwv;
      olast_q <= nlast;
      oaddr_q <= naddr;
      ochar_q <= nchar;
      oattr_q <= nattr;
      ocur_q  <= cursor_q;
      oview_q <= view_q;
    end
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tuser[0] = owv_q;
  assign m_axis_tlast    = olast_q;
  assign m_axis_tdata    = {PAD_W'(0), oview_q, ocur_q, oattr_q, ochar_q, oaddr_q};

endmodule

`default_nettype wire

[sv/text_console_writer_top.sv]
// Sequence: an accepted print item steps through execute, scroll check and emit before its first
// result is registered (a scroll or unknown opcode goes from execute to emit); a taken newline at
// or past the base adds a wait for the row offset, a taken backspace a cell read, and each row
// scrolled a scroll check pass. Each cell write (a tab writes 4) is one result; the next item can
// be taken the cycle after the last result is loaded. Reset: cursor and view to 0; a pass then
// fills all 16384 cells with spaces, taking no item (configuration writes are taken throughout).
`default_nettype none
`include "text_console_writer_top_defines.svh"

module text_console_writer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [tcw_pkg::CHAR_W-1:0]        s_axis_tdata,   // char_code
  input  wire logic [tcw_pkg::OP_W-1:0]          s_axis_tuser,   // opcode
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // cell_address, cell_char, cell_attr, cursor_pos, view_start, zero pad
  output logic [tcw_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic [0:0]                             m_axis_tuser,   // write_valid
  output logic                                   m_axis_tlast
);

  logic [tcw_pkg::ADDR_W-1:0]  base_q;
  logic [tcw_pkg::CELLS_W-1:0] cells_q;
  logic [tcw_pkg::ATTR_W-1:0]  attr_q;
  tcw_pkg::cfg_t               cfg;
  tcw_pkg::mem_req_t           mem_req;
  logic [tcw_pkg::CHAR_W-1:0]  mem_rdata;
  tcw_pkg::row_req_t           row_req;
  tcw_pkg::row_rsp_t           row_rsp;
  logic                        nowrite_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= tcw_pkg::ADDR_W'(0);
      cells_q <= tcw_pkg::CELLS_W'(5461);
      attr_q  <= tcw_pkg::ATTR_W'(7);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tcw_pkg::CFG_REGION_BASE:  base_q  <= cfg_data_i[tcw_pkg::ADDR_W-1:0];
        tcw_pkg::CFG_REGION_CELLS: cells_q <= cfg_data_i[tcw_pkg::CELLS_W-1:0];
        tcw_pkg::CFG_DEFAULT_ATTR: attr_q  <= cfg_data_i[tcw_pkg::ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.base  = base_q;
  assign cfg.cells = cells_q;
  assign cfg.attr  = attr_q;

  tcw_cell_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tcw_row_calc u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (row_req),
    .rsp_o  (row_rsp)
  );

  tcw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .row_req_o     (row_req),
    .row_rsp_i     (row_rsp)
  );

  assign nowrite_out = m_axis_tvalid && !m_axis_tuser[0];

  // an item that writes no cell gives exactly one result
  `TCW_ASSERT_NOW(a_nowrite_last, nowrite_out, m_axis_tlast, "no-write result not last")
  `TCW_ASSERT_NOW(a_nowrite_zero, nowrite_out, m_axis_tdata[29:0] == 30'd0, "no-write cell data")
  // cell store is only written while clearing or emitting, never while waiting for an item
  `TCW_ASSERT_NOW(a_idle_no_write, s_axis_tready, !(mem_req.en && mem_req.we), "write while idle")
  `TCW_ASSERT_TWO(a_row_latency, row_req.start, row_rsp.done, "row offset late")

endmodule

`default_nettype wire
